@@ hdl/sorted_key_table_macros.svh @@
// ----------------------------------------------------------------------------
// sorted_key_table_macros
// Assertion macros shared by the sorted key table RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset
`define SKT_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted_key_table: assertion failed");

// Next-cycle implication, clocked on clk, off during reset
`define SKT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted_key_table: assertion failed");

`endif

@@ hdl/skt_pkg.sv @@
// ----------------------------------------------------------------------------
// skt_pkg
// Types and codes for the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

	// default table depth
	localparam int SKT_CAPACITY = 8;

	// operation codes
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_SEARCH = 2'd1;
	localparam logic [1:0] KIND_REMOVE = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_MISS = 2'd2;

	// command broadcast to every cell
	typedef struct packed {
		logic               ins;
		logic               rm;
		logic signed [31:0] key;
		logic        [31:0] tag;
		logic        [2:0]  position;
	} skt_cmd_t;

	// search result handed along the chain
	typedef struct packed {
		logic        hit;
		logic [2:0]  position;
		logic [31:0] tag;
	} skt_hit_t;

endpackage

@@ hdl/skt_in_if.sv @@
// ----------------------------------------------------------------------------
// skt_in_if
// Request channel: valid/ready handshake with one table operation.
// ----------------------------------------------------------------------------
interface skt_in_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  kind;
	logic signed [31:0] key;
	logic        [31:0] tag;
	logic        [2:0]  position;

	modport source (output valid, kind, key, tag, position, input ready);
	modport sink   (input valid, kind, key, tag, position, output ready);
endinterface

@@ hdl/skt_out_if.sv @@
// ----------------------------------------------------------------------------
// skt_out_if
// Response channel: valid/ready handshake with one operation result.
// ----------------------------------------------------------------------------
interface skt_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        found;
	logic [2:0]  found_position;
	logic [31:0] found_tag;
	logic [3:0]  occupancy;

	modport source (output valid, status, found, found_position, found_tag, occupancy,
		input ready);
	modport sink   (input valid, status, found, found_position, found_tag, occupancy,
		output ready);
endinterface

@@ hdl/sorted_key_table.sv @@
// Response: a result is registered in the cycle after its request is accepted.
// Throughput: one operation per cycle unless rsp stalls; every cell compares in parallel and
//   shifts one place in the same cycle, the search hit ripples down the chain.
// Reset: arst_n clears the entry count and the response valid; slot contents
//   are not cleared and are only read below the count.
// ----------------------------------------------------------------------------
// sorted_key_table
// Fixed-capacity table of (key, tag) entries in ascending signed key order,
// built as a chain of slot cells with insert, search and remove.
// ----------------------------------------------------------------------------
`include "sorted_key_table_macros.svh"

module sorted_key_table import skt_pkg::*; #(
	parameter int CAPACITY = SKT_CAPACITY
) (
	input  logic       clk,
	input  logic       arst_n,
	skt_in_if.sink     req,
	skt_out_if.source  rsp
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_next;
	logic               accept;
	logic               full;
	logic               pos_ok;
	skt_cmd_t           cmd;

	logic [CAPACITY-1:0] cell_valid;
	logic [CAPACITY-1:0] cell_le;
	logic [CAPACITY-1:0] left_le;
	logic signed [31:0]  cell_key  [CAPACITY];
	logic        [31:0]  cell_tag  [CAPACITY];
	logic signed [31:0]  left_key  [CAPACITY];
	logic        [31:0]  left_tag  [CAPACITY];
	logic signed [31:0]  right_key [CAPACITY];
	logic        [31:0]  right_tag [CAPACITY];
	skt_hit_t            hit_chain [CAPACITY+1];

	logic               rsp_valid_q;
	logic [1:0]         status_q;
	logic               found_q;
	logic [2:0]         found_position_q;
	logic [31:0]        found_tag_q;
	logic [3:0]         occupancy_q;
	logic [1:0]         status_d;
	logic               found_d;

	// handshake: a new request enters while the response slot drains
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign full   = (count_q == CW'(CAPACITY));
	assign pos_ok = (32'(req.position) < 32'(count_q));

	// command broadcast to the cells
	always_comb begin
		cmd.ins      = accept && (req.kind == KIND_INSERT) && !full;
		cmd.rm       = accept && (req.kind == KIND_REMOVE) && pos_ok;
		cmd.key      = req.key;
		cmd.tag      = req.tag;
		cmd.position = req.position;
	end

	// cell chain
	assign hit_chain[0] = '0;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		assign cell_valid[g] = (count_q > CW'(g));

		if (g == 0) begin : g_first
			assign left_le[g]  = 1'b1;
			assign left_key[g] = cell_key[g];
			assign left_tag[g] = cell_tag[g];
		end else begin : g_mid
			assign left_le[g]  = cell_le[g-1];
			assign left_key[g] = cell_key[g-1];
			assign left_tag[g] = cell_tag[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_key[g] = cell_key[g];
			assign right_tag[g] = cell_tag[g];
		end else begin : g_inner
			assign right_key[g] = cell_key[g+1];
			assign right_tag[g] = cell_tag[g+1];
		end

		skt_cell #(
			.INDEX (g)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.valid     (cell_valid[g]),
			.le_left   (left_le[g]),
			.key_left  (left_key[g]),
			.tag_left  (left_tag[g]),
			.key_right (right_key[g]),
			.tag_right (right_tag[g]),
			.hit_in    (hit_chain[g]),
			.le        (cell_le[g]),
			.key       (cell_key[g]),
			.tag       (cell_tag[g]),
			.hit_out   (hit_chain[g+1])
		);
	end

	// entry count after this operation
	always_comb begin
		count_next = count_q;
		if (cmd.ins) begin
			count_next = count_q + 1'b1;
		end else if (cmd.rm) begin
			count_next = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	// result status and found flag
	always_comb begin
		status_d = ST_MISS;
		found_d  = 1'b0;
		unique case (req.kind)
			KIND_INSERT: status_d = full ? ST_FULL : ST_OK;
			KIND_SEARCH: begin
				found_d  = hit_chain[CAPACITY].hit;
				status_d = found_d ? ST_OK : ST_MISS;
			end
			KIND_REMOVE: status_d = pos_ok ? ST_OK : ST_MISS;
			default:     status_d = ST_MISS;
		endcase
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q         <= status_d;
			found_q          <= found_d;
			found_position_q <= found_d ? hit_chain[CAPACITY].position : 3'd0;
			found_tag_q      <= found_d ? hit_chain[CAPACITY].tag : 32'd0;
			occupancy_q      <= 4'(count_next);
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = status_q;
	assign rsp.found          = found_q;
	assign rsp.found_position = found_position_q;
	assign rsp.found_tag      = found_tag_q;
	assign rsp.occupancy      = occupancy_q;

	// checks
	`SKT_ASSERT_IMPL(a_count_bound, 1'b1, 32'(count_q) <= CAPACITY)
	`SKT_ASSERT_NEXT(a_full_holds, accept && (req.kind == KIND_INSERT) && full, (status_q == ST_FULL) && $stable(count_q))
	`SKT_ASSERT_NEXT(a_remove_dec, cmd.rm, count_q == $past(count_q) - 1'b1)
	`SKT_ASSERT_IMPL(a_found_ok, rsp_valid_q && found_q, status_q == ST_OK)

endmodule

@@ hdl/skt_cell.sv @@
// ----------------------------------------------------------------------------
// skt_cell
// One table slot: holds a key and tag, compares against the broadcast key,
// and takes its neighbor's entry when the table shifts.
// ----------------------------------------------------------------------------
module skt_cell import skt_pkg::*; #(
	parameter int INDEX = 0
) (
	input  logic               clk,
	input  skt_cmd_t           cmd,
	input  logic               valid,
	input  logic               le_left,
	input  logic signed [31:0] key_left,
	input  logic        [31:0] tag_left,
	input  logic signed [31:0] key_right,
	input  logic        [31:0] tag_right,
	input  skt_hit_t           hit_in,
	output logic               le,
	output logic signed [31:0] key,
	output logic        [31:0] tag,
	output skt_hit_t           hit_out
);

	logic signed [31:0] key_q;
	logic        [31:0] tag_q;
	logic               ins_here;
	logic               shift_up;
	logic               shift_down;
	logic               match;

	// ordering and equality against the broadcast key
	assign le    = valid && (key_q <= cmd.key);
	assign match = valid && (key_q == cmd.key);

	// first slot that is empty or whose key is above the new key takes it; later slots move up
	assign ins_here   = cmd.ins && !le && le_left;
	assign shift_up   = cmd.ins && !le && !le_left;
	assign shift_down = cmd.rm && (INDEX >= int'(cmd.position));

	// slot update; insert and remove never coincide, idle slots hold
	always_ff @(posedge clk) begin
		if (ins_here) begin
			key_q <= cmd.key;
			tag_q <= cmd.tag;
		end else if (shift_up) begin
			key_q <= key_left;
			tag_q <= tag_left;
		end else if (shift_down) begin
			key_q <= key_right;
			tag_q <= tag_right;
		end
	end

	// first match wins: an earlier hit passes through
	always_comb begin
		hit_out = hit_in;
		if (!hit_in.hit && match) begin
			hit_out.hit      = 1'b1;
			hit_out.position = 3'(INDEX);
			hit_out.tag      = tag_q;
		end
	end

	assign key = key_q;
	assign tag = tag_q;

endmodule

@@ verif/tb_sorted_key_table.sv @@
// ----------------------------------------------------------------------------
// tb_sorted_key_table
// Self-checking bench for the sorted key table. A shadow copy of the table
// predicts every response. A short directed run covers the key and tag
// extremes, duplicate keys, the full table, misses, bad positions and the
// unused operation code. Random traffic follows in four idling phases and
// alternates between filling and draining the table. A long receiver
// hold-off backs the block up, and the sender pauses at the end of each
// phase until every response has come back.
// ----------------------------------------------------------------------------
module tb_sorted_key_table;
	timeunit 1ns;
	timeprecision 1ps;

	import skt_pkg::*;

	localparam int         DEPTH       = SKT_CAPACITY;
	localparam logic [1:0] KIND_NONE   = 2'd3;   // unused operation code
	localparam int         LONG_HOLD   = 40;
	localparam int         PHASE_ITEMS = 225;

	// one predicted response
	typedef struct {
		logic [1:0]  status;
		logic        found;
		logic [2:0]  found_position;
		logic [31:0] found_tag;
		logic [3:0]  occupancy;
	} table_response_t;

	// Shadow of the table contents; predicts and checks every response.
	class table_shadow;
		logic signed [31:0] keys[DEPTH];
		logic        [31:0] tags[DEPTH];
		int                 count;
		table_response_t    pending_responses[$];
		int                 failures;

		function new();
			count = 0;
			failures = 0;
		endfunction

		function int pending();
			return pending_responses.size();
		endfunction

		function logic signed [31:0] key_at(int idx);
			return keys[idx];
		endfunction

		// apply an accepted request to the shadow, queue its response
		function void apply_request(logic [1:0] kind, logic signed [31:0] key,
				logic [31:0] tag, logic [2:0] position);
			table_response_t r;
			int at;
			int i;
			r.status = ST_MISS;
			r.found = 1'b0;
			r.found_position = '0;
			r.found_tag = '0;
			case (kind)
				KIND_INSERT: begin
					if (count >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						// new entry goes after every key <= it
						at = 0;
						while (at < count && keys[at] <= key)
							at++;
						for (i = count; i > at; i--) begin
							keys[i] = keys[i - 1];
							tags[i] = tags[i - 1];
						end
						keys[at] = key;
						tags[at] = tag;
						count++;
						r.status = ST_OK;
					end
				end
				KIND_SEARCH: begin
					// lowest matching position wins
					for (i = 0; i < count && !r.found; i++) begin
						if (keys[i] == key) begin
							r.found = 1'b1;
							r.found_position = i[2:0];
							r.found_tag = tags[i];
							r.status = ST_OK;
						end
					end
				end
				KIND_REMOVE: begin
					if (position < count) begin
						for (i = position; i + 1 < count; i++) begin
							keys[i] = keys[i + 1];
							tags[i] = tags[i + 1];
						end
						count--;
						r.status = ST_OK;
					end
				end
				default: ;
			endcase
			r.occupancy = count[3:0];
			pending_responses.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0h, got %0h", name, want, got);
				failures++;
			end
		endfunction

		// compare an accepted response with the oldest prediction
		function void check_response(logic [1:0] status, logic found,
				logic [2:0] found_position, logic [31:0] found_tag, logic [3:0] occupancy);
			table_response_t r;
			if (pending_responses.size() == 0) begin
				$error("response with no request outstanding");
				failures++;
				return;
			end
			r = pending_responses.pop_front();
			compare_field("status", 32'(r.status), 32'(status));
			compare_field("found", 32'(r.found), 32'(found));
			compare_field("found_position", 32'(r.found_position), 32'(found_position));
			compare_field("found_tag", r.found_tag, found_tag);
			compare_field("occupancy", 32'(r.occupancy), 32'(occupancy));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic hold_req = 1'b0;
	int   idle_pct = 0;
	int   stall_pct = 0;

	table_shadow shadow = new();

	skt_in_if  req_ch();
	skt_out_if rsp_ch();

	sorted_key_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	// watchdog
	initial begin
		#2_000_000;
		$display("sorted_key_table verification failed");
		$finish;
	end

	// transaction monitor on both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				shadow.apply_request(req_ch.kind, req_ch.key, req_ch.tag, req_ch.position);
			if (rsp_ch.valid && rsp_ch.ready)
				shadow.check_response(rsp_ch.status, rsp_ch.found, rsp_ch.found_position,
					rsp_ch.found_tag, rsp_ch.occupancy);
		end
	end

	// response side: random stalls, plus one long hold-off on request
	initial begin
		int held;
		bit hold_done;
		hold_done = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				for (held = 0; held < LONG_HOLD; held++) begin
					rsp_ch.ready <= 1'b0;
					@(posedge clk);
				end
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// offer one request and hold it until accepted
	task automatic send_op(input logic [1:0] kind, input logic signed [31:0] key,
			input logic [31:0] tag, input logic [2:0] position);
		while ($urandom_range(0, 99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.kind     <= kind;
		req_ch.key      <= key;
		req_ch.tag      <= tag;
		req_ch.position <= position;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	// stop offering until every response is back
	task automatic drain();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (shadow.pending() != 0);
	endtask

	// keys mostly collide with stored ones so searches hit and duplicates occur
	function automatic logic signed [31:0] pick_key();
		int sel;
		logic signed [31:0] k;
		sel = $urandom_range(0, 99);
		if (sel < 40 && shadow.count > 0)
			k = shadow.key_at($urandom_range(0, shadow.count - 1));
		else if (sel < 70)
			k = int'($urandom_range(0, 6)) - 3;
		else if (sel < 90)
			k = $urandom;
		else begin
			case ($urandom_range(0, 3))
				0:       k = 32'h8000_0000;
				1:       k = 32'h7FFF_FFFF;
				2:       k = 32'h0000_0000;
				default: k = 32'hFFFF_FFFF;
			endcase
		end
		return k;
	endfunction

	// one random request, biased toward filling or draining the table
	task automatic random_op(input bit filling);
		int roll;
		logic [1:0] kind;
		logic [2:0] position;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			kind = KIND_NONE;
		else if (roll < (filling ? 55 : 25))
			kind = KIND_INSERT;
		else if (roll < (filling ? 80 : 50))
			kind = KIND_SEARCH;
		else
			kind = KIND_REMOVE;
		if (shadow.count > 0 && $urandom_range(0, 99) < 80)
			position = 3'($urandom_range(0, shadow.count - 1));
		else
			position = 3'($urandom_range(0, 7));
		send_op(kind, pick_key(), $urandom, position);
	endtask

	// main sequence
	initial begin
		int phase;
		int n;
		int idle_set[4];
		int stall_set[4];
		idle_set  = '{0, 63, 0, 35};
		stall_set = '{0, 0, 63, 35};

		arst_n          <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.kind     <= KIND_INSERT;
		req_ch.key      <= '0;
		req_ch.tag      <= '0;
		req_ch.position <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: miss on search, bad position on remove, unused code
		send_op(KIND_SEARCH, 32'sd0, 32'h0, 3'd0);
		send_op(KIND_REMOVE, 32'sd0, 32'h0, 3'd0);
		send_op(KIND_NONE, 32'sd7, 32'h1234_5678, 3'd7);
		// fill with extremes and duplicates
		send_op(KIND_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 3'd0);
		send_op(KIND_INSERT, 32'h8000_0000, 32'h0000_0000, 3'd0);
		send_op(KIND_INSERT, 32'sd0, 32'h0000_0001, 3'd0);
		send_op(KIND_INSERT, -32'sd1, 32'hA5A5_A5A5, 3'd0);
		send_op(KIND_INSERT, 32'sd0, 32'h0000_0002, 3'd0);
		send_op(KIND_INSERT, 32'sd5, 32'h5A5A_5A5A, 3'd0);
		send_op(KIND_INSERT, -32'sd1, 32'h8000_0000, 3'd0);
		send_op(KIND_INSERT, 32'sd100, 32'h7FFF_FFFF, 3'd0);
		// full table
		send_op(KIND_INSERT, 32'sd3, 32'hDEAD_BEEF, 3'd0);
		send_op(KIND_SEARCH, 32'sd0, 32'h0, 3'd0);
		send_op(KIND_SEARCH, 32'h7FFF_FFFF, 32'h0, 3'd0);
		send_op(KIND_SEARCH, 32'h8000_0000, 32'h0, 3'd0);
		send_op(KIND_SEARCH, 32'sd42, 32'h0, 3'd0);
		send_op(KIND_NONE, 32'sd0, 32'h0, 3'd0);
		// removes at the ends, past the count and in the middle
		send_op(KIND_REMOVE, 32'sd0, 32'h0, 3'd7);
		send_op(KIND_REMOVE, 32'sd0, 32'h0, 3'd0);
		send_op(KIND_REMOVE, 32'sd0, 32'h0, 3'd7);
		send_op(KIND_REMOVE, 32'sd0, 32'h0, 3'd3);
		send_op(KIND_SEARCH, -32'sd1, 32'h0, 3'd0);
		send_op(KIND_REMOVE, 32'sd0, 32'h0, 3'd5);
		drain();

		// random traffic, one idling profile per phase
		for (phase = 0; phase < 4; phase++) begin
			idle_pct  = idle_set[phase];
			stall_pct = stall_set[phase];
			for (n = 0; n < PHASE_ITEMS; n++) begin
				random_op(((n / 40) % 2) == 0);
				if (phase == 0 && n == 60)
					hold_req <= 1'b1;
			end
			drain();
		end

		repeat (4) @(posedge clk);
		if (shadow.failures == 0 && shadow.pending() == 0)
			$display("sorted_key_table verification clean");
		else
			$display("sorted_key_table verification failed");
		$finish;
	end

endmodule
